// ===== rtl/jacs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Joystick axis calibrate/scale package
// Shared widths, reset values, register indexes and the types that pass
// between the range store, the serial divider and the top level.
// ============================================================================
package jacs_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_BITS    = 12;
	localparam int AXIS_BITS      = 2;
	localparam int POS_BITS       = 12;
	localparam int THRESH_BITS    = SAMPLE_BITS + 1;
	localparam int RANGE_MIN_BITS = SAMPLE_BITS + 1;
	localparam int MASK_BITS      = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = THRESH_BITS;

	// Default number of stored axes.
	localparam int AXIS_COUNT_DEF = 4;

	// Scaling: position = (sample - min) * 2^SCALE_SHIFT / span - FULL_SCALE.
	localparam int SCALE_SHIFT = 11;
	localparam int FULL_SCALE  = 1024;
	localparam int STEP_BITS   = $clog2(SCALE_SHIFT + 1);

	// Reset values of the registers and the per-axis range.
	localparam logic [SAMPLE_BITS-1:0]    DEAD_LOW_RESET  = 12'd1948;
	localparam logic [SAMPLE_BITS-1:0]    DEAD_HIGH_RESET = 12'd2148;
	localparam logic [THRESH_BITS-1:0]    THRESH_RESET    = 13'd2048;
	localparam logic                      CAL_RESET       = 1'b1;
	localparam logic [MASK_BITS-1:0]      INVERT_RESET    = 4'd9;
	localparam logic [RANGE_MIN_BITS-1:0] RANGE_MIN_RESET = RANGE_MIN_BITS'(1 << SAMPLE_BITS);
	localparam logic [SAMPLE_BITS-1:0]    RANGE_MAX_RESET = '0;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DEAD_LOW    = 3'd0,
		REG_DEAD_HIGH   = 3'd1,
		REG_THRESHOLD   = 3'd2,
		REG_CALIBRATE   = 3'd3,
		REG_INVERT_MASK = 3'd4
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_CLASSIFY,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Request to the range store: one range update and read per beat.
	typedef struct packed {
		logic                   valid;
		logic [AXIS_BITS-1:0]   axis;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   calibrate;
		logic [THRESH_BITS-1:0] threshold;
	} range_req_t;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/jacs_range.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Per-axis range store
// Holds the minimum and maximum seen on each axis, widens them while
// calibration is on and the span is below the threshold, and registers the
// updated range of the requested axis.
// ============================================================================
module jacs_range #(
	parameter int AXIS_COUNT = jacs_pkg::AXIS_COUNT_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  jacs_pkg::range_req_t                    req,
	output logic [jacs_pkg::RANGE_MIN_BITS-1:0]     lo_q,
	output logic [jacs_pkg::SAMPLE_BITS-1:0]        hi_q
);
	import jacs_pkg::*;

	localparam int IDX_BITS = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	logic [RANGE_MIN_BITS-1:0] min_q [AXIS_COUNT];
	logic [SAMPLE_BITS-1:0]    max_q [AXIS_COUNT];

	logic [IDX_BITS-1:0]       idx;
	logic [RANGE_MIN_BITS-1:0] cur_min;
	logic [SAMPLE_BITS-1:0]    cur_max;
	logic signed [SAMPLE_BITS+1:0] span;
	logic                      widen;
	logic [RANGE_MIN_BITS-1:0] new_min;
	logic [SAMPLE_BITS-1:0]    new_max;

	// Span check and widening of the selected axis.
	always_comb begin
		idx     = IDX_BITS'(req.axis);
		cur_min = min_q[idx];
		cur_max = max_q[idx];
		span    = $signed({2'b00, cur_max}) - $signed({1'b0, cur_min});
		widen   = req.calibrate && (span < $signed({1'b0, req.threshold}));
		new_min = (widen && ({1'b0, req.sample} < cur_min)) ? {1'b0, req.sample} : cur_min;
		new_max = (widen && (req.sample > cur_max)) ? req.sample : cur_max;
	end

	// Range storage; cleared to an empty range at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_COUNT; i++) begin
				min_q[i] <= RANGE_MIN_RESET;
				max_q[i] <= RANGE_MAX_RESET;
			end
		end else if (req.valid) begin
			min_q[idx] <= new_min;
			max_q[idx] <= new_max;
		end
	end

	// Updated range of the current beat, read by the scaler.
	always_ff @(posedge clk) begin
		if (req.valid) begin
			lo_q <= new_min;
			hi_q <= new_max;
		end
	end

endmodule

// ===== rtl/jacs_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Serial scaling divider
// Computes floor(x * 2^SCALE_SHIFT / d) for x <= d, one quotient bit per
// cycle with a restoring remainder step.
// ============================================================================
module jacs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [jacs_pkg::SAMPLE_BITS-1:0]    x,
	input  logic [jacs_pkg::SAMPLE_BITS-1:0]    d,
	output logic [jacs_pkg::SAMPLE_BITS-1:0]    quot_q,
	output jacs_pkg::div_stat_t                 stat
);
	import jacs_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_BITS-1:0]   cnt_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] d_q;

	logic                   first_ge;
	logic [SAMPLE_BITS:0]   rem2;
	logic                   ge;
	logic [SAMPLE_BITS-1:0] rem_next;

	// One restoring step: shift the remainder and try to subtract.
	always_comb begin
		first_ge = (x >= d);
		rem2     = {rem_q, 1'b0};
		ge       = (rem2 >= {1'b0, d_q});
		rem_next = ge ? SAMPLE_BITS'(rem2 - {1'b0, d_q}) : SAMPLE_BITS'(rem2);
	end

	// Step counter and handshake with the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_BITS'(SCALE_SHIFT);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register; the integer bit comes first.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= SAMPLE_BITS'(first_ge);
			rem_q  <= first_ge ? x - d : x;
			d_q    <= d;
		end else if (busy_q) begin
			quot_q <= {quot_q[SAMPLE_BITS-2:0], ge};
			rem_q  <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/joystick_axis_calibrate_scale_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Joystick axis calibrate/scale unit
// Tracks each axis's range from converter samples and scales a sample to a
// signed position with a central dead band and per-axis inversion.
// ============================================================================
// Usage:
//   Input channel (sample_valid / sample_stall) carries an axis number and a
//   12-bit sample; a beat moves when valid is high and stall is low.
//   Output channel (result_valid / result_stall) carries the axis number and
//   the signed position, held in an output register until taken.
//   The configuration port writes a register on any cycle with cfg_wr_en
//   high; write it only while no beat is in flight.
// Timing:
//   A beat goes through the update, classify and finish steps to the output
//   register when the result is decided directly (dead band, empty span, out
//   of range), with a divide step between classify and finish otherwise; the
//   divider sets the integer quotient bit at start and then produces one bit
//   a cycle for 11 bits. One beat is worked on at a time and the input
//   reopens the cycle after the result is registered.
// Reset:
//   Config, state and result valid reset; every axis range is emptied.
// Stall:
//   A stalled result holds; the next beat is still accepted and processed,
//   and waits in its final step until the output register frees up.
// ============================================================================
module joystick_axis_calibrate_scale_unit #(
	parameter int AXIS_COUNT = jacs_pkg::AXIS_COUNT_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     sample_valid,
	output logic                                     sample_stall,
	input  logic [jacs_pkg::AXIS_BITS-1:0]           axis,
	input  logic [jacs_pkg::SAMPLE_BITS-1:0]         sample,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic [jacs_pkg::AXIS_BITS-1:0]           axis_out,
	output logic signed [jacs_pkg::POS_BITS-1:0]     position,
	input  logic                                     cfg_wr_en,
	input  logic [jacs_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [jacs_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
	import jacs_pkg::*;

	// Configuration registers.
	logic [SAMPLE_BITS-1:0] dead_low_q;
	logic [SAMPLE_BITS-1:0] dead_high_q;
	logic [THRESH_BITS-1:0] thresh_q;
	logic                   cal_q;
	logic [MASK_BITS-1:0]   invert_q;

	// Beat in flight.
	state_t                 state_q;
	state_t                 state_d;
	logic [AXIS_BITS-1:0]   axis_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   axis_ok_q;
	logic signed [POS_BITS-1:0] base_q;

	// Output register.
	logic                   result_valid_q;
	logic [AXIS_BITS-1:0]   axis_out_q;
	logic signed [POS_BITS-1:0] position_q;

	// Submodule connections.
	range_req_t             range_req;
	logic [RANGE_MIN_BITS-1:0] lo;
	logic [SAMPLE_BITS-1:0] hi;
	logic                   div_start;
	logic [SAMPLE_BITS-1:0] div_x;
	logic [SAMPLE_BITS-1:0] div_d;
	logic [SAMPLE_BITS-1:0] quot;
	div_stat_t              div_stat;

	// Decode signals.
	logic                   accept;
	logic                   out_free;
	logic                   dead;
	logic                   no_span;
	logic                   below;
	logic                   above;
	logic                   take_div;
	logic signed [POS_BITS-1:0] direct_pos;
	logic signed [POS_BITS:0]   div_pos;
	logic signed [POS_BITS-1:0] final_pos;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_low_q  <= DEAD_LOW_RESET;
			dead_high_q <= DEAD_HIGH_RESET;
			thresh_q    <= THRESH_RESET;
			cal_q       <= CAL_RESET;
			invert_q    <= INVERT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEAD_LOW:    dead_low_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_DEAD_HIGH:   dead_high_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_THRESHOLD:   thresh_q    <= cfg_data[THRESH_BITS-1:0];
				REG_CALIBRATE:   cal_q       <= cfg_data[0];
				REG_INVERT_MASK: invert_q    <= cfg_data[MASK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Range update request, issued in the cycle after acceptance.
	always_comb begin
		range_req.valid     = (state_q == ST_UPDATE) && axis_ok_q;
		range_req.axis      = axis_q;
		range_req.sample    = sample_q;
		range_req.calibrate = cal_q;
		range_req.threshold = thresh_q;
	end

	jacs_range #(
		.AXIS_COUNT(AXIS_COUNT)
	) u_range (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (range_req),
		.lo_q  (lo),
		.hi_q  (hi)
	);

	// Classification of the sample against the dead band and the range.
	always_comb begin
		dead     = (sample_q >= dead_low_q) && (sample_q <= dead_high_q);
		no_span  = ({1'b0, hi} <= lo);
		below    = ({1'b0, sample_q} < lo);
		above    = (sample_q > hi);
		take_div = axis_ok_q && !dead && !no_span && !below && !above;
		div_x    = sample_q - lo[SAMPLE_BITS-1:0];
		div_d    = hi - lo[SAMPLE_BITS-1:0];
		if (!axis_ok_q || dead || no_span) begin
			direct_pos = '0;
		end else if (below) begin
			direct_pos = -POS_BITS'(FULL_SCALE);
		end else begin
			direct_pos = POS_BITS'(FULL_SCALE);
		end
	end

	jacs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.x     (div_x),
		.d     (div_d),
		.quot_q(quot),
		.stat  (div_stat)
	);

	// The quotient never exceeds twice full scale, so no clamp is needed.
	assign div_pos   = $signed({1'b0, quot}) - $signed((POS_BITS+1)'(FULL_SCALE));
	assign final_pos = invert_q[axis_q] ? -base_q : base_q;

	// Sequencer next state.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				if (take_div) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DIVIDE: begin
				if (div_stat.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Beat payload and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q    <= axis;
			sample_q  <= sample;
			axis_ok_q <= (32'(axis) < AXIS_COUNT);
		end
		if (state_q == ST_CLASSIFY) begin
			base_q <= direct_pos;
		end else if (state_q == ST_DIVIDE && div_stat.done) begin
			base_q <= POS_BITS'(div_pos);
		end
		if (state_q == ST_FINISH && out_free) begin
			axis_out_q <= axis_q;
			position_q <= final_pos;
		end
	end

	assign result_valid = result_valid_q;
	assign axis_out     = axis_out_q;
	assign position     = position_q;

	// An accepted beat always enters the range update step first.
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPDATE))
		else $error("accepted beat did not enter the update step");

	// A new result only appears from the final step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared outside the final step");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide step");

	// The divider only works while the sequencer is in the divide step.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIVIDE))
		else $error("divider busy outside the divide step");

	// Positions stay within full scale.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ((position_q <= $signed(POS_BITS'(FULL_SCALE)))
			&& (position_q >= -$signed(POS_BITS'(FULL_SCALE)))))
		else $error("position outside full scale");

endmodule
